FILE: rtl/dss_pkg.sv
package dss_pkg;

    // Configuration port widths and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_LEVEL   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_AMPLITUDE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_RATE     = 3'd4;

    // Rotator datapath word, Q4.30 for x and y, turns for z.
    typedef logic signed [33:0] cordic_word_t;

    // Envelope in Q1.32, where 1.0 is 2^32.
    typedef logic [32:0] env_t;

    localparam cordic_word_t CORDIC_GAIN = 34'sd652032874;
    localparam logic [30:0]  EXP_M1      = 31'd1580030169;
    localparam logic [37:0]  EXP_LIMIT   = 38'd137438953472;
    localparam env_t         ONE_Q32     = 33'h1_0000_0000;

    // Envelope pipeline shape: two front stages, three stages per series
    // term, one clamp stage and one stage per possible whole-unit decay.
    localparam int SERIES_TERMS  = 13;
    localparam int POWER_STAGES  = 31;
    localparam int ENV_LAT       = 2 + 3 * SERIES_TERMS + 1 + POWER_STAGES;

    // Arctangent of 2^-i in Q0.32 turns.
    function automatic logic [29:0] atan_turns(input logic [4:0] i);
        logic [29:0] a;
        case (i)
            5'd0:    a = 30'd536870912;
            5'd1:    a = 30'd316933406;
            5'd2:    a = 30'd167458907;
            5'd3:    a = 30'd85004756;
            5'd4:    a = 30'd42667331;
            5'd5:    a = 30'd21354465;
            5'd6:    a = 30'd10679838;
            5'd7:    a = 30'd5340245;
            5'd8:    a = 30'd2670163;
            5'd9:    a = 30'd1335087;
            5'd10:   a = 30'd667544;
            5'd11:   a = 30'd333772;
            5'd12:   a = 30'd166886;
            5'd13:   a = 30'd83443;
            5'd14:   a = 30'd41722;
            5'd15:   a = 30'd20861;
            5'd16:   a = 30'd10430;
            5'd17:   a = 30'd5215;
            5'd18:   a = 30'd2608;
            5'd19:   a = 30'd1304;
            5'd20:   a = 30'd652;
            5'd21:   a = 30'd326;
            5'd22:   a = 30'd163;
            5'd23:   a = 30'd81;
            5'd24:   a = 30'd41;
            5'd25:   a = 30'd20;
            5'd26:   a = 30'd10;
            5'd27:   a = 30'd5;
            5'd28:   a = 30'd3;
            5'd29:   a = 30'd1;
            5'd30:   a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/dss_cordic.sv
module dss_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [15:0] sine
);

    localparam dss_pkg::cordic_word_t QUARTER = 34'sd1073741824;
    localparam dss_pkg::cordic_word_t HALF    = 34'sd2147483648;

    dss_pkg::cordic_word_t x_reg [0:ITERATIONS];
    dss_pkg::cordic_word_t y_reg [0:ITERATIONS];
    dss_pkg::cordic_word_t z_reg [0:ITERATIONS];

    dss_pkg::cordic_word_t a_ext;
    dss_pkg::cordic_word_t a_fold;
    logic [33:0]           y_mag;
    logic [33:0]           y_rnd;
    logic signed [15:0]    sine_next;
    logic signed [15:0]    sine_reg;

    // Fold the phase into the quarter turn either side of zero.
    always_comb
    begin
        a_ext = dss_pkg::cordic_word_t'({{2{phase[31]}}, phase});
        if (a_ext > QUARTER)
        begin
            a_fold = HALF - a_ext;
        end
        else if (a_ext < -QUARTER)
        begin
            a_fold = -HALF - a_ext;
        end
        else
        begin
            a_fold = a_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= dss_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= a_fold;
        end
    end

    // One rotation step per stage.
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
        localparam dss_pkg::cordic_word_t ATAN =
            dss_pkg::cordic_word_t'({4'b0, dss_pkg::atan_turns(5'(i))});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end
    end

    // Round y to Q1.15, half away from zero, and saturate.
    always_comb
    begin
        y_mag = y_reg[ITERATIONS][33] ? 34'(-y_reg[ITERATIONS]) : 34'(y_reg[ITERATIONS]);
        y_rnd = (y_mag + 34'd16384) >> 15;
        if (y_reg[ITERATIONS][33])
        begin
            sine_next = (y_rnd > 34'd32768) ? -16'sd32768 : 16'(-y_rnd);
        end
        else
        begin
            sine_next = (y_rnd > 34'd32767) ? 16'sd32767 : 16'(y_rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

FILE: rtl/dss_envelope.sv
module dss_envelope (
    input  logic                clk,
    input  logic                en,
    input  logic [63:0]         elapsed,
    input  logic [31:0]         rate,
    output dss_pkg::env_t       env
);

    localparam int NT = dss_pkg::SERIES_TERMS;
    localparam int NP = dss_pkg::POWER_STAGES;

    // Values that ride along the series stages.
    typedef struct packed {
        logic signed [34:0] sum;
        logic [31:0]        f;
        logic [4:0]         n;
        logic               zero;
    } ser_ctx_t;

    logic [63:0]   hp_reg;
    logic [63:0]   lp_reg;
    logic          too_big;
    logic [37:0]   e_val;
    ser_ctx_t      ctx_next;

    dss_pkg::env_t term_reg [0:NT];
    ser_ctx_t      ctx_reg  [0:NT];
    logic [31:0]   xa_reg   [0:NT-1];
    ser_ctx_t      ctxa_reg [0:NT-1];
    logic [31:0]   xb_reg   [0:NT-1];
    logic [31:0]   qb_reg   [0:NT-1];
    ser_ctx_t      ctxb_reg [0:NT-1];

    dss_pkg::env_t pw_reg   [0:NP];
    logic [4:0]    pn_reg   [0:NP];
    dss_pkg::env_t clamp_next;

    // Split the exponent product into high and low halves.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp_reg <= 64'(elapsed[63:32]) * 64'(rate);
            lp_reg <= 64'(elapsed[31:0]) * 64'(rate);
        end
    end

    // Join the halves and split into whole part and fraction.
    always_comb
    begin
        too_big = (hp_reg >= 64'd32) || (lp_reg >= 64'(dss_pkg::EXP_LIMIT));
        e_val   = {1'b0, hp_reg[4:0], 32'b0} + {1'b0, lp_reg[36:0]};
        ctx_next.zero = too_big || (e_val >= dss_pkg::EXP_LIMIT);
        ctx_next.n    = e_val[36:32];
        ctx_next.f    = e_val[31:0];
        ctx_next.sum  = 35'sh1_0000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg[0] <= dss_pkg::ONE_Q32;
            ctx_reg[0]  <= ctx_next;
        end
    end

    // Each series term: multiply by the fraction, divide by k, accumulate.
    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int          K     = j + 1;
        localparam logic [35:0] RECIP = 36'((64'd1 << 35) / K);
        localparam bit          ODD   = (K % 2) == 1;

        logic [35:0] rem;
        logic [32:0] term_next;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xa_reg[j]   <= 32'((65'(term_reg[j]) * 65'(ctx_reg[j].f)) >> 32);
                ctxa_reg[j] <= ctx_reg[j];
            end
        end

        // Reciprocal estimate, at most one below the true quotient.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xb_reg[j]   <= xa_reg[j];
                qb_reg[j]   <= 32'((68'(xa_reg[j]) * 68'(RECIP)) >> 35);
                ctxb_reg[j] <= ctxa_reg[j];
            end
        end

        always_comb
        begin
            rem = 36'(xb_reg[j]) - 36'(qb_reg[j]) * 36'(K);
            term_next = (rem >= 36'(K)) ? 33'(qb_reg[j]) + 33'd1 : 33'(qb_reg[j]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[j+1]     <= term_next;
                ctx_reg[j+1].f    <= ctxb_reg[j].f;
                ctx_reg[j+1].n    <= ctxb_reg[j].n;
                ctx_reg[j+1].zero <= ctxb_reg[j].zero;
                if (ODD)
                begin
                    ctx_reg[j+1].sum <= ctxb_reg[j].sum - 35'(term_next);
                end
                else
                begin
                    ctx_reg[j+1].sum <= ctxb_reg[j].sum + 35'(term_next);
                end
            end
        end
    end

    // Clamp the series to [0, 1.0]; a large exponent gives zero.
    always_comb
    begin
        if (ctx_reg[NT].zero || ctx_reg[NT].sum[34])
        begin
            clamp_next = '0;
        end
        else if (ctx_reg[NT].sum > 35'sh1_0000_0000)
        begin
            clamp_next = dss_pkg::ONE_Q32;
        end
        else
        begin
            clamp_next = 33'(ctx_reg[NT].sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg[0] <= clamp_next;
            pn_reg[0] <= ctx_reg[NT].n;
        end
    end

    // Multiply by exp(-1) once for each whole unit of the exponent.
    for (genvar j = 0; j < NP; j++) begin : g_power
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pn_reg[j+1] <= pn_reg[j];
                if (5'(j) < pn_reg[j])
                begin
                    pw_reg[j+1] <= 33'((64'(pw_reg[j]) * 64'(dss_pkg::EXP_M1)) >> 32);
                end
                else
                begin
                    pw_reg[j+1] <= pw_reg[j];
                end
            end
        end
    end

    assign env = pw_reg[NP];

endmodule

FILE: rtl/damped_sine_source_unit.sv
// Channel   | Direction | Handshake            | Payload
// config    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// input     | in        | in_valid/in_stall    | time_point
// output    | out       | out_valid/out_stall  | source_value, clipped
//
// One time point is taken every cycle unless the pipeline is frozen; the
// delay from a time point to its result is set by the envelope pipeline
// (series terms at three stages each, one stage per whole unit of decay).
// cfg_ready is always high. Reset clears the valid bits and loads the
// register defaults. When the output register holds a result and out_stall
// is high, the whole pipeline freezes and in_stall is raised.
module damped_sine_source_unit #(
    parameter int TIME_BITS       = 48,
    parameter int SINE_ITERATIONS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [TIME_BITS-1:0]            time_point,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              source_value,
    output logic                            clipped
);

    localparam int          PIPE  = dss_pkg::ENV_LAT + 2;
    localparam int          QDLY  = dss_pkg::ENV_LAT - 4 - SINE_ITERATIONS;
    localparam logic [63:0] TMASK = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
    localparam logic signed [33:0] NEG_MIN = -34'sd2147483648;

    logic signed [31:0] offset_level_reg;
    logic signed [31:0] peak_amplitude_reg;
    logic [31:0]        phase_step_reg;
    logic [47:0]        start_delay_reg;
    logic [31:0]        decay_rate_reg;

    logic               en;
    logic [PIPE-1:0]    vld_reg;
    logic [PIPE-1:0]    act_reg;
    logic [63:0]        t64;
    logic [63:0]        d64;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [31:0]        phase_reg;
    logic signed [15:0] sine;
    dss_pkg::env_t      env;

    logic [31:0]        amp_mag;
    logic [15:0]        sine_mag;
    logic [31:0]        q_next;
    logic [31:0]        qd_reg  [0:QDLY];
    logic               negd_reg [0:QDLY];
    logic [31:0]        mag_reg;
    logic               neg_reg;

    logic signed [33:0] ev;
    logic               out_valid_reg;
    logic signed [31:0] source_value_reg;
    logic               clipped_reg;
    logic signed [31:0] source_value_next;
    logic               clipped_next;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_level_reg   <= '0;
            peak_amplitude_reg <= 32'sd65536;
            phase_step_reg     <= '0;
            start_delay_reg    <= '0;
            decay_rate_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dss_pkg::REG_OFFSET_LEVEL:   offset_level_reg   <= cfg_data[31:0];
                dss_pkg::REG_PEAK_AMPLITUDE: peak_amplitude_reg <= cfg_data[31:0];
                dss_pkg::REG_PHASE_STEP:     phase_step_reg     <= cfg_data[31:0];
                dss_pkg::REG_START_DELAY:    start_delay_reg    <= cfg_data;
                dss_pkg::REG_DECAY_RATE:     decay_rate_reg     <= cfg_data[31:0];
                default:                     ;
            endcase
        end
    end

    // The pipeline advances unless a finished result is being held.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE-2:0], in_valid};
        end
    end

    // Elapsed time since the delay, and whether the sine has started.
    assign t64 = 64'(time_point) & TMASK;
    assign d64 = 64'(start_delay_reg) & TMASK;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg     <= {act_reg[PIPE-2:0], t64 > d64};
            elapsed_reg <= TIME_BITS'(t64 - d64);
        end
    end

    // Phase in turns, wrapping modulo one turn.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_reg <= 32'(64'(phase_step_reg) * (64'(elapsed_reg) & 64'hFFFF_FFFF));
        end
    end

    dss_cordic #(
        .ITERATIONS (SINE_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .en    (en),
        .phase (phase_reg),
        .sine  (sine)
    );

    dss_envelope u_envelope (
        .clk     (clk),
        .en      (en),
        .elapsed (64'(elapsed_reg)),
        .rate    (decay_rate_reg),
        .env     (env)
    );

    // Amplitude times sine, rounded to Q16.16.
    always_comb
    begin
        amp_mag  = peak_amplitude_reg[31] ? 32'(-peak_amplitude_reg) : 32'(peak_amplitude_reg);
        sine_mag = sine[15] ? 16'(-sine) : 16'(sine);
        q_next   = 32'((48'(amp_mag) * 48'(sine_mag) + 48'h4000) >> 15);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qd_reg[0]   <= q_next;
            negd_reg[0] <= peak_amplitude_reg[31] ^ sine[15];
        end
    end

    // Hold the sine product until the envelope catches up.
    for (genvar i = 0; i < QDLY; i++) begin : g_align
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qd_reg[i+1]   <= qd_reg[i];
                negd_reg[i+1] <= negd_reg[i];
            end
        end
    end

    // Apply the envelope, rounding half up.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= 32'((66'(qd_reg[QDLY]) * 66'(env) + 66'h8000_0000) >> 32);
            neg_reg <= negd_reg[QDLY];
        end
    end

    // Add the offset and saturate.
    always_comb
    begin
        if (!act_reg[PIPE-1])
        begin
            ev = 34'(offset_level_reg);
        end
        else if (neg_reg)
        begin
            ev = 34'(offset_level_reg) - $signed({2'b0, mag_reg});
        end
        else
        begin
            ev = 34'(offset_level_reg) + $signed({2'b0, mag_reg});
        end

        if (ev > POS_MAX)
        begin
            source_value_next = 32'sh7FFF_FFFF;
            clipped_next      = 1'b1;
        end
        else if (ev < NEG_MIN)
        begin
            source_value_next = 32'sh8000_0000;
            clipped_next      = 1'b1;
        end
        else
        begin
            source_value_next = 32'(ev);
            clipped_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            source_value_reg <= source_value_next;
            clipped_reg      <= clipped_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_value = source_value_reg;
    assign clipped      = clipped_reg;

`ifndef SYNTHESIS
    // A clipped result always sits on one of the two bounds.
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> source_value == 32'sh7FFF_FFFF
                                 || source_value == 32'sh8000_0000)
        else $error("clipped result not at a bound");

    // A frozen pipeline keeps its valid bits.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved while stalled");

    // With no damping the envelope is exactly one.
    a_unit_env: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[dss_pkg::ENV_LAT] && decay_rate_reg == 32'd0 |-> env == dss_pkg::ONE_Q32)
        else $error("envelope not one without damping");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

// Expected result of one time point.
typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
} sample_t;

// Waveform predictor and store of the samples still to come.
class waveform_scoreboard;
    logic signed [31:0] offs;
    logic signed [31:0] amp;
    logic [31:0]        step;
    logic [47:0]        delay;
    logic [31:0]        rate;
    sample_t            pending[$];
    int                 errors;
    int                 checked;

    // Arctangent of 2^-i in turns, Q0.32.
    longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861};

    function new();
        offs = 0;
        amp = 32'sd65536;
        step = 0;
        delay = 0;
        rate = 0;
        errors = 0;
        checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
        case (idx)
            dss_pkg::REG_OFFSET_LEVEL:   offs = data[31:0];
            dss_pkg::REG_PEAK_AMPLITUDE: amp = data[31:0];
            dss_pkg::REG_PHASE_STEP:     step = data[31:0];
            dss_pkg::REG_START_DELAY:    delay = data;
            dss_pkg::REG_DECAY_RATE:     rate = data[31:0];
            default: ;
        endcase
    endfunction

    // Rotation-mode sine of a phase in turns, rounded to Q1.15.
    function longint sine_q15(logic [31:0] ph);
        longint a, x, y, z, xs, ys;
        longint unsigned mag;
        a = ph[31] ? longint'(ph) - 64'sd4294967296 : longint'(ph);
        if (a > 64'sd1073741824)
            a = 64'sd2147483648 - a;
        else if (a < -64'sd1073741824)
            a = -64'sd2147483648 - a;
        x = 64'sd652032874;
        y = 0;
        z = a;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end
        end
        mag = (y < 0) ? longint'(-y) : longint'(y);
        mag = (mag + 64'd16384) >> 15;
        if (y < 0)
            return (mag > 32768) ? -64'sd32768 : -longint'(mag);
        return (mag > 32767) ? 64'sd32767 : longint'(mag);
    endfunction

    // Decay envelope exp(-rate*elapsed/2^32) in Q0.32.
    function longint unsigned envelope(logic [47:0] elapsed);
        longint unsigned hp, lp, e, f, term, n;
        longint sum;
        hp = longint'(elapsed[47:32]) * rate;
        lp = longint'(elapsed[31:0]) * rate;
        if (hp >= 32 || lp >= 64'd137438953472)
            return 0;
        e = (hp << 32) + lp;
        if (e >= 64'd137438953472)
            return 0;
        n = e >> 32;
        f = e & 64'hFFFF_FFFF;
        term = 64'h1_0000_0000;
        sum = 64'sh1_0000_0000;
        for (int k = 1; k <= 13; k++)
        begin
            term = ((term * f) >> 32) / k;
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sh1_0000_0000)
            sum = 64'sh1_0000_0000;
        term = sum;
        for (longint unsigned k = 0; k < n; k++)
            term = (term * 64'd1580030169) >> 32;
        return term;
    endfunction

    // Work out the sample for an accepted time point.
    function void note_time(logic [47:0] t);
        longint ev, s, a;
        longint unsigned q, ma, ms;
        logic [47:0] elapsed;
        logic [31:0] ph;
        sample_t exp_s;
        ev = longint'(offs);
        exp_s.clip = 0;
        if (t > delay)
        begin
            elapsed = t - delay;
            ph = 32'(longint'(step) * longint'(elapsed));
            s = sine_q15(ph);
            a = longint'(amp);
            ma = (a < 0) ? -a : a;
            ms = (s < 0) ? -s : s;
            q = (ma * ms + 64'd16384) >> 15;
            if (rate != 0)
                q = (q * envelope(elapsed) + 64'h8000_0000) >> 32;
            if ((a < 0) != (s < 0))
                ev = ev - longint'(q);
            else
                ev = ev + longint'(q);
        end
        if (ev > 64'sd2147483647)
        begin
            ev = 64'sd2147483647;
            exp_s.clip = 1;
        end
        else if (ev < -64'sd2147483648)
        begin
            ev = -64'sd2147483648;
            exp_s.clip = 1;
        end
        exp_s.value = ev[31:0];
        pending.push_back(exp_s);
    endfunction

    // Compare a delivered sample with the oldest one expected.
    function void check_sample(logic signed [31:0] value, logic clip);
        sample_t exp_s;
        if (pending.size() == 0)
        begin
            $error("unexpected sample: source_value %0d clipped %0b", value, clip);
            errors++;
            return;
        end
        exp_s = pending.pop_front();
        checked++;
        if (value !== exp_s.value)
        begin
            $error("source_value: expected %0d, got %0d", exp_s.value, value);
            errors++;
        end
        if (clip !== exp_s.clip)
        begin
            $error("clipped: expected %0b, got %0b", exp_s.clip, clip);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam logic [2:0] REG_SPARE     = dss_pkg::REG_DECAY_RATE + 3'd1;
    localparam logic [2:0] REG_TOP_SPARE = 3'd7;
    localparam int LIMIT_CYCLES = 1000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [47:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [47:0]        time_point;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] source_value;
    logic               clipped;

    waveform_scoreboard sb = new();
    bit                 calm;
    int                 cycles;
    int                 sent;
    int                 cfg_writes;

    damped_sine_source_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .time_point(time_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .source_value(source_value), .clipped(clipped)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Output side: check each transfer, then decide on the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                sb.check_sample(source_value, clipped);
            out_stall <= !calm && ($urandom_range(99) < 22);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // One time point, sometimes with a one-cycle gap in front of it.
    task automatic send_time(logic [47:0] t);
        if (!calm && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        time_point <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_time(t);
        sent++;
    endtask

    // Let every outstanding sample arrive and the pipeline empty.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // A time point mostly shortly after the delay, otherwise anywhere.
    function automatic logic [47:0] pick_time();
        if ($urandom_range(99) < 60)
            return sb.delay + 48'($urandom_range(2000));
        return rand48();
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom) >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        cycles = 0;
        sent = 0;
        cfg_writes = 0;
        calm = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        time_point = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: time zero, the delay edge and the far end of time.
        send_time(48'd0);
        send_time(48'd1);
        send_time(48'hFFFF_FFFF_FFFF);
        drain();

        // Quarter-turn steps, a delay and undamped sine.
        write_reg(dss_pkg::REG_PHASE_STEP, 48'h4000_0000);
        write_reg(dss_pkg::REG_START_DELAY, 48'd100);
        write_reg(dss_pkg::REG_PEAK_AMPLITUDE, 48'h7FFF_FFFF);
        for (int i = 99; i < 105; i++)
            send_time(48'(i));
        drain();

        // Amplitude and offset extremes drive the sum into both bounds.
        write_reg(dss_pkg::REG_OFFSET_LEVEL, 48'h7FFF_0000);
        send_time(48'd101);
        send_time(48'd103);
        drain();
        write_reg(dss_pkg::REG_PEAK_AMPLITUDE, 48'h8000_0000);
        write_reg(dss_pkg::REG_OFFSET_LEVEL, 48'h8000_0000);
        send_time(48'd101);
        send_time(48'd103);
        drain();

        // Damping: mild, then so strong that the envelope vanishes at later times.
        write_reg(dss_pkg::REG_DECAY_RATE, 48'h0100_0000);
        write_reg(dss_pkg::REG_OFFSET_LEVEL, 48'd0);
        send_time(48'd101);
        send_time(48'd150);
        drain();
        write_reg(dss_pkg::REG_DECAY_RATE, 48'hFFFF_FFFF);
        send_time(48'd101);
        send_time(48'd140);
        send_time(48'hFFFF_FFFF_FFFF);
        drain();

        // Writes to an unused index must change nothing.
        write_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_TOP_SPARE, 48'hFFFF_FFFF_FFFF);
        send_time(48'd101);
        send_time(48'd102);
        drain();

        // Random settings, each followed by a run of time points.
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(dss_pkg::REG_OFFSET_LEVEL, {16'($urandom), pick_word()});
            write_reg(dss_pkg::REG_PEAK_AMPLITUDE, {16'($urandom), pick_word()});
            write_reg(dss_pkg::REG_PHASE_STEP, {16'($urandom), 32'($urandom)});
            write_reg(dss_pkg::REG_START_DELAY,
                ($urandom_range(3) == 0) ? rand48() : 48'($urandom_range(1000)));
            write_reg(dss_pkg::REG_DECAY_RATE,
                ($urandom_range(3) == 0) ? 48'd0 : {16'($urandom), pick_word()});
            calm = (ph == 4);
            for (int i = 0; i < 200; i++)
                send_time(pick_time());
            calm = 0;
            drain();
        end

        $display("Checked %0d samples from %0d time points over %0d register writes.",
            sb.checked, sent, cfg_writes);
        $display("Settings covered saturation, strong and zero damping, and start delays.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
